[hdl/sq_decoded_ip_score_topk_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the decoded inner product scorer
// Concurrent checks, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef SQ_DECODED_IP_SCORE_TOPK_TOP_DEFINES_SVH
`define SQ_DECODED_IP_SCORE_TOPK_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define SQD_ASSERT_CLK(label, aclk, arst_n, prop) \
  label: assert property (@(posedge aclk) disable iff (!arst_n) prop) \
    else $error("sqd assertion failed");
`define SQD_ASSERT(label, prop) `SQD_ASSERT_CLK(label, clk, rst_n, prop)
`else
`define SQD_ASSERT_CLK(label, aclk, arst_n, prop)
`define SQD_ASSERT(label, prop)
`endif
`endif

[hdl/sqd_pkg.sv]
// ----------------------------------------------------------------------------
// sqd_pkg
// Types and constants of the decoded inner product scorer.
// ----------------------------------------------------------------------------
`default_nettype none
package sqd_pkg;

  localparam int DIM_BITS  = 10;
  localparam int DIM_DEPTH = 1024;
  localparam int STEP_BITS = 23;
  localparam int VAL_BITS  = 24;
  localparam int ID_W      = 20;
  localparam logic [7:0] LEV_RESET = 8'd15;
  localparam logic signed [63:0] SCORE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SCORE_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_SCORE = 2'd1,
    REQ_EMIT  = 2'd2,
    REQ_NONE  = 2'd3
  } sqd_req_t;

  typedef struct packed {
    logic [1:0]                   req_type;
    logic [DIM_BITS-1:0]          dim_index;
    logic signed [VAL_BITS-1:0]   value_a;
    logic signed [VAL_BITS-1:0]   value_b;
    logic [ID_W-1:0]              vector_id;
    logic                         last_element;
  } sqd_in_t;

  typedef struct packed {
    logic [3:0]         rank;
    logic [ID_W-1:0]    best_vector_id;
    logic signed [63:0] score;
    logic               entry_valid;
    logic               last_of_run;
  } sqd_out_t;

  typedef struct packed {
    logic signed [VAL_BITS-1:0] low;
    logic [STEP_BITS-1:0]       step;
  } sqd_ruler_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_CODE, ST_DECODE, ST_MUL, ST_ACC, ST_BIAS_GO, ST_BIAS,
    ST_PROD_LO, ST_PROD_HI, ST_SCALE, ST_INSERT, ST_SETTLE, ST_EMIT
  } sqd_state_t;

  typedef enum logic [1:0] {
    BS_IDLE, BS_DIV, BS_SQRT, BS_DONE
  } sqd_bstate_t;

endpackage
`default_nettype wire

[hdl/sqd_ruler_mem.sv]
// ----------------------------------------------------------------------------
// sqd_ruler_mem
// Ruler table, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module sqd_ruler_mem (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [sqd_pkg::DIM_BITS-1:0] waddr,
  input  wire sqd_pkg::sqd_ruler_t          wdata,
  input  wire logic                         re,
  input  wire logic [sqd_pkg::DIM_BITS-1:0] raddr,
  output sqd_pkg::sqd_ruler_t               rdata
);
  import sqd_pkg::*;

  sqd_ruler_t mem [DIM_DEPTH];
  sqd_ruler_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[hdl/sqd_bias.sv]
// ----------------------------------------------------------------------------
// sqd_bias
// Norm ratio bias: long division then bitwise square root, Q16.16 result.
// ----------------------------------------------------------------------------
`default_nettype none
module sqd_bias (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] v2,
  input  wire logic [63:0] r2,
  output logic             done,
  output logic [31:0]      bias
);
  import sqd_pkg::*;

  sqd_bstate_t state_r, state_nxt;
  logic [6:0]  cnt_r;
  logic [63:0] den_r, rem_r, op_r, res_r, one_r;
  logic [95:0] num_r;
  logic        sat_r;

  logic [64:0] rem_sh;
  logic        qbit;
  logic [63:0] rem_nxt;
  logic [95:0] num_nxt;
  logic [63:0] trial;

  always_comb begin
    rem_sh  = {rem_r, num_r[95]};
    qbit    = (rem_sh >= {1'b0, den_r});
    rem_nxt = qbit ? 64'(rem_sh - {1'b0, den_r}) : rem_sh[63:0];
    num_nxt = {num_r[94:0], qbit};
    trial   = res_r + one_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BS_IDLE: if (start) state_nxt = BS_DIV;
      BS_DIV:  if (cnt_r == 7'd95) state_nxt = BS_SQRT;
      BS_SQRT: if (cnt_r == 7'd31) state_nxt = BS_DONE;
      BS_DONE: state_nxt = BS_IDLE;
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_comb begin
    done = (state_r == BS_DONE);
    bias = sat_r ? 32'hFFFF_FFFF : res_r[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BS_IDLE || state_nxt != state_r) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BS_IDLE: begin
        if (start) begin
          den_r <= (r2 == '0) ? 64'd1 : r2;
          num_r <= {v2, 32'd0};
          rem_r <= '0;
        end
      end
      BS_DIV: begin
        rem_r <= rem_nxt;
        num_r <= num_nxt;
        if (cnt_r == 7'd95) begin
          op_r  <= num_nxt[63:0];
          sat_r <= |num_nxt[95:64];
          res_r <= '0;
          one_r <= 64'h4000_0000_0000_0000;
        end
      end
      BS_SQRT: begin
        if (op_r >= trial) begin
          op_r  <= op_r - trial;
          res_r <= (res_r >> 1) + one_r;
        end else begin
          res_r <= res_r >> 1;
        end
        one_r <= one_r >> 2;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

[hdl/sqd_topk.sv]
// ----------------------------------------------------------------------------
// sqd_topk
// Ranked best list: compare against all entries, then shift in.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sq_decoded_ip_score_topk_top_defines.svh"
module sqd_topk #(
  parameter int TOP_K = 10,
  parameter int IW    = (TOP_K > 1) ? $clog2(TOP_K) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     ins_go,
  input  wire logic signed [63:0]       ins_score,
  input  wire logic [sqd_pkg::ID_W-1:0] ins_id,
  input  wire logic                     clear,
  input  wire logic [IW-1:0]            rd_idx,
  output logic signed [63:0]            rd_score,
  output logic [sqd_pkg::ID_W-1:0]      rd_id,
  output logic                          rd_valid
);
  import sqd_pkg::*;

  localparam int CW = $clog2(TOP_K + 1);

  logic signed [63:0] score_r [TOP_K];
  logic [ID_W-1:0]    id_r    [TOP_K];
  logic signed [63:0] prev_s  [TOP_K];
  logic [ID_W-1:0]    prev_i  [TOP_K];
  logic [CW-1:0]      cnt_r;
  logic [TOP_K-1:0]   ge_r, ge_nxt;
  logic               pend_r;
  logic signed [63:0] s_r;
  logic [ID_W-1:0]    sid_r;
  logic [CW-1:0]      pos;

  always_comb begin
    for (int i = 0; i < TOP_K; i++) begin
      ge_nxt[i] = (CW'(i) < cnt_r) && (score_r[i] >= ins_score);
    end
    prev_s[0] = score_r[0];
    prev_i[0] = id_r[0];
    for (int i = 1; i < TOP_K; i++) begin
      prev_s[i] = score_r[i-1];
      prev_i[i] = id_r[i-1];
    end
    pos = CW'($countones(ge_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      pend_r <= ins_go;
      if (clear) begin
        cnt_r <= '0;
      end else if (pend_r && pos < CW'(TOP_K) && cnt_r < CW'(TOP_K)) begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ins_go) begin
      ge_r  <= ge_nxt;
      s_r   <= ins_score;
      sid_r <= ins_id;
    end
    if (pend_r && pos < CW'(TOP_K)) begin
      for (int i = 0; i < TOP_K; i++) begin
        if (CW'(i) == pos) begin
          score_r[i] <= s_r;
          id_r[i]    <= sid_r;
        end else if (CW'(i) > pos) begin
          score_r[i] <= prev_s[i];
          id_r[i]    <= prev_i[i];
        end
      end
    end
  end

  always_comb begin
    rd_valid = (CW'(rd_idx) < cnt_r);
    rd_score = score_r[rd_idx];
    rd_id    = id_r[rd_idx];
  end

  `SQD_ASSERT(a_cnt_bound, cnt_r <= CW'(TOP_K))
  `SQD_ASSERT(a_no_ins_overlap, pend_r |-> !ins_go)
  `SQD_ASSERT(a_clear_empty, (clear && !pend_r) |=> (cnt_r == '0))

endmodule
`default_nettype wire

[hdl/sq_decoded_ip_score_topk_top.sv]
// Per item: a load writes the ruler table; a score element runs an 8-step code search;
//   a last element then adds a 96-step divide and 32-step square root in the bias unit.
// Throughput: one item at a time; an emit sends TOP_K transfers, one per cycle
//   while out_ready is high.
// Reset: synchronous active-low rst_n clears control state, accumulators and
//   list count; the ruler table is not cleared and is valid once loaded.
// ----------------------------------------------------------------------------
// sq_decoded_ip_score_topk_top
// Scalar-quantized inner product scorer with a running best list.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sq_decoded_ip_score_topk_top_defines.svh"
module sq_decoded_ip_score_topk_top #(
  parameter int TOP_K = 10
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sqd_pkg::sqd_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sqd_pkg::sqd_out_t      out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [7:0]        cfg_data
);
  import sqd_pkg::*;

  localparam int IW = (TOP_K > 1) ? $clog2(TOP_K) : 1;

  sqd_state_t state_r, state_nxt;
  logic [7:0] lev_r;

  logic signed [23:0] a_r, b_r, low_r;
  logic [ID_W-1:0]    id_r;
  logic               last_r;
  logic [22:0]        step_r;
  logic [25:0]        num_r;
  logic [23:0]        den_r;
  logic [7:0]         code_r;
  logic [2:0]         bit_r;
  logic signed [32:0] r_r;
  logic signed [56:0] pdot_r;
  logic [47:0]        pvv_r;
  logic [63:0]        prr_r;
  logic signed [63:0] dot_r;
  logic [63:0]        v2_r, r2_r, mag_r, plo_r, phi_r;
  logic               neg_r;
  logic signed [63:0] score_r;
  logic [IW-1:0]      e_r;
  logic               out_valid_r;
  sqd_out_t           out_r;

  logic       accept, ram_we, ram_re, bias_go, ins_go, list_clear, out_load;
  sqd_ruler_t ram_wdata, ram_rdata;
  logic       bias_done;
  logic [31:0] bias;
  logic signed [63:0] rd_score;
  logic [ID_W-1:0]    rd_id;
  logic               rd_valid;

  logic [22:0]        step_eff;
  logic signed [24:0] diff;
  logic [7:0]         cand, cl;
  logic [31:0]        cprod;
  logic [30:0]        sc;
  logic signed [47:0] vv_full;
  logic signed [65:0] rr_full;
  logic signed [64:0] dsum;
  logic [64:0]        vsum, rsum;
  logic [95:0]        sum96;
  logic [63:0]        q;
  logic signed [63:0] score_nxt;

  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign ram_wdata.low  = in_data.value_a;
  assign ram_wdata.step = (in_data.value_b < 24'sd1) ? 23'd1 : in_data.value_b[22:0];

  sqd_ruler_mem u_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_data.dim_index),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (in_data.dim_index),
    .rdata (ram_rdata)
  );

  sqd_bias u_bias (
    .clk   (clk),
    .rst_n (rst_n),
    .start (bias_go),
    .v2    (v2_r),
    .r2    (r2_r),
    .done  (bias_done),
    .bias  (bias)
  );

  sqd_topk #(.TOP_K(TOP_K), .IW(IW)) u_topk (
    .clk       (clk),
    .rst_n     (rst_n),
    .ins_go    (ins_go),
    .ins_score (score_r),
    .ins_id    (id_r),
    .clear     (list_clear),
    .rd_idx    (e_r),
    .rd_score  (rd_score),
    .rd_id     (rd_id),
    .rd_valid  (rd_valid)
  );

  always_comb begin
    step_eff = (ram_rdata.step == '0) ? 23'd1 : ram_rdata.step;
    diff     = 25'(a_r) - 25'(ram_rdata.low);
    cand     = code_r | (8'd1 << bit_r);
    cprod    = cand * den_r;
    cl       = (code_r > lev_r) ? lev_r : code_r;
    sc       = step_r * cl;
    vv_full  = 48'(a_r) * 48'(a_r);
    rr_full  = 66'(r_r) * 66'(r_r);
    dsum     = 65'(dot_r) + 65'(pdot_r);
    vsum     = {1'b0, v2_r} + {17'd0, pvv_r};
    rsum     = {1'b0, r2_r} + {1'b0, prr_r};
    sum96    = {32'd0, plo_r} + {phi_r, 32'd0} + (neg_r ? 96'hFFFF : 96'd0);
    q        = sum96[79:16];
    if (|sum96[95:80]) begin
      score_nxt = neg_r ? SCORE_MIN : SCORE_MAX;
    end else if (!neg_r) begin
      score_nxt = q[63] ? SCORE_MAX : $signed(q);
    end else begin
      score_nxt = q[63] ? SCORE_MIN : -$signed(q);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.req_type)
            REQ_SCORE: state_nxt = ST_READ;
            REQ_EMIT:  state_nxt = ST_EMIT;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_READ:    state_nxt = ST_CODE;
      ST_CODE:    if (bit_r == 3'd0) state_nxt = ST_DECODE;
      ST_DECODE:  state_nxt = ST_MUL;
      ST_MUL:     state_nxt = ST_ACC;
      ST_ACC:     state_nxt = last_r ? ST_BIAS_GO : ST_IDLE;
      ST_BIAS_GO: state_nxt = ST_BIAS;
      ST_BIAS:    if (bias_done) state_nxt = ST_PROD_LO;
      ST_PROD_LO: state_nxt = ST_PROD_HI;
      ST_PROD_HI: state_nxt = ST_SCALE;
      ST_SCALE:   state_nxt = ST_INSERT;
      ST_INSERT:  state_nxt = ST_SETTLE;
      ST_SETTLE:  state_nxt = ST_IDLE;
      ST_EMIT:    if (out_load && e_r == IW'(TOP_K - 1)) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    ram_we     = accept && (in_data.req_type == REQ_LOAD);
    ram_re     = accept && (in_data.req_type == REQ_SCORE);
    bias_go    = (state_r == ST_BIAS_GO);
    ins_go     = (state_r == ST_INSERT);
    out_load   = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
    list_clear = out_load && (e_r == IW'(TOP_K - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lev_r       <= LEV_RESET;
      e_r         <= '0;
      out_valid_r <= 1'b0;
      dot_r       <= '0;
      v2_r        <= '0;
      r2_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        lev_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        e_r         <= (e_r == IW'(TOP_K - 1)) ? '0 : e_r + IW'(1);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_ACC) begin
        dot_r <= (dsum[64] != dsum[63]) ? (dsum[64] ? SCORE_MIN : SCORE_MAX)
                                        : dsum[63:0];
        v2_r  <= vsum[64] ? '1 : vsum[63:0];
        r2_r  <= rsum[64] ? '1 : rsum[63:0];
      end else if (state_r == ST_BIAS_GO) begin
        dot_r <= '0;
        v2_r  <= '0;
        r2_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_r    <= in_data.value_a;
      b_r    <= in_data.value_b;
      id_r   <= in_data.vector_id;
      last_r <= in_data.last_element;
    end
    case (state_r)
      ST_READ: begin
        low_r  <= ram_rdata.low;
        step_r <= step_eff;
        num_r  <= (diff > 25'sd0) ? 26'({diff[24:0], 1'b0}) + 26'(step_eff) : '0;
        den_r  <= {step_eff, 1'b0};
        code_r <= '0;
        bit_r  <= 3'd7;
      end
      ST_CODE: begin
        if (cprod <= {6'd0, num_r}) begin
          code_r <= cand;
        end
        bit_r <= bit_r - 3'd1;
      end
      ST_DECODE: r_r <= 33'(low_r) + $signed({2'b00, sc});
      ST_MUL: begin
        pdot_r <= 57'(b_r) * 57'(r_r);
        pvv_r  <= vv_full;
        prr_r  <= rr_full[63:0];
      end
      ST_BIAS_GO: begin
        neg_r <= dot_r[63];
        mag_r <= dot_r[63] ? 64'(-dot_r) : dot_r;
      end
      ST_PROD_LO: plo_r <= mag_r[31:0] * bias;
      ST_PROD_HI: phi_r <= mag_r[63:32] * bias;
      ST_SCALE:   score_r <= score_nxt;
      default: begin
      end
    endcase
    if (out_load) begin
      out_r.rank           <= 4'(e_r);
      out_r.best_vector_id <= rd_valid ? rd_id : '0;
      out_r.score          <= rd_valid ? rd_score : '0;
      out_r.entry_valid    <= rd_valid;
      out_r.last_of_run    <= (e_r == IW'(TOP_K - 1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `SQD_ASSERT(a_emit_idx_rest, (state_r != ST_EMIT) |-> (e_r == '0))
  `SQD_ASSERT(a_acc_clear, (state_r == ST_BIAS_GO) |=> (dot_r == '0 && v2_r == '0))
  `SQD_ASSERT(a_done_in_wait, bias_done |-> (state_r == ST_BIAS))

endmodule
`default_nettype wire

[verif/sq_decoded_ip_score_topk_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Decoded inner product scorer testbench
// Loads ruler entries, streams quantized vectors and emit requests through the
// valid/ready channels with random idling on both sides, and checks every
// ranked transfer against a scoring and ranking predictor kept in this bench.
// ----------------------------------------------------------------------------
`default_nettype none
module sq_decoded_ip_score_topk_top_tb;
  import sqd_pkg::*;

  localparam int BEST_N = 10;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 400;
  localparam int RULER_DIMS = 8;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  sqd_in_t in_data;
  logic out_valid;
  logic out_ready;
  sqd_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [7:0] cfg_data;

  sq_decoded_ip_score_topk_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predictor state
  logic [7:0] lev;
  logic signed [23:0] rl_low [DIM_DEPTH];
  logic [22:0] rl_step [DIM_DEPTH];
  logic signed [63:0] dot_sum;
  logic [63:0] vnorm_sum;
  logic [63:0] rnorm_sum;
  logic signed [63:0] top_score [BEST_N];
  logic [19:0] top_id [BEST_N];
  int top_cnt;

  sqd_out_t ranked_q[$];
  int errors;
  int cycles;
  logic calm;
  logic rx_calm;
  int rx_idle;
  sqd_out_t typed_first;
  logic typed_pending;
  logic [7:0] lev_plan [5] = '{8'd1, 8'd255, 8'd0, 8'd7, 8'd15};

  function automatic logic [31:0] norm_ratio_q16(logic [63:0] v2, logic [63:0] r2);
    logic [63:0] den;
    logic [31:0] b;
    logic [31:0] c;
    logic [127:0] lhs;
    den = (r2 == 0) ? 64'd1 : r2;
    b = 0;
    for (int i = 31; i >= 0; i--) begin
      c = b | (32'd1 << i);
      lhs = {64'd0, {32'd0, c} * {32'd0, c}} * {64'd0, den};
      if (lhs <= {32'd0, v2, 32'd0}) b = c;
    end
    return b;
  endfunction

  function automatic logic signed [63:0] biased_score(logic signed [63:0] dot,
                                                      logic [31:0] bias);
    logic neg;
    logic [63:0] mag;
    logic [127:0] p;
    logic [111:0] q;
    neg = dot[63];
    mag = neg ? -dot : dot;
    p = {64'd0, mag} * {96'd0, bias};
    if (neg) p = p + 128'hFFFF;
    q = p[127:16];
    if (!neg) return (q > 112'h7FFF_FFFF_FFFF_FFFF) ? SCORE_MAX : q[63:0];
    if (q >= 112'h8000_0000_0000_0000) return SCORE_MIN;
    return -$signed(q[63:0]);
  endfunction

  task automatic rank_insert(logic signed [63:0] s, logic [19:0] id);
    int p;
    int i;
    p = 0;
    while (p < top_cnt && top_score[p] >= s) p++;
    if (p < BEST_N) begin
      i = (top_cnt < BEST_N) ? top_cnt : BEST_N - 1;
      for (; i > p; i--) begin
        top_score[i] = top_score[i-1];
        top_id[i] = top_id[i-1];
      end
      top_score[p] = s;
      top_id[p] = id;
      if (top_cnt < BEST_N) top_cnt++;
    end
  endtask

  task automatic predict_item(sqd_in_t it);
    int d;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] lo;
    logic signed [63:0] st;
    logic signed [63:0] diff;
    logic signed [63:0] code;
    logic signed [63:0] r;
    logic signed [64:0] sd;
    logic [64:0] su;
    sqd_out_t o;
    d = it.dim_index;
    a = it.value_a;
    b = it.value_b;
    case (it.req_type)
      REQ_LOAD: begin
        rl_low[d] = it.value_a;
        rl_step[d] = (b < 1) ? 23'd1 : b[22:0];
      end
      REQ_SCORE: begin
        lo = rl_low[d];
        st = (rl_step[d] == 0) ? 64'sd1 : {41'd0, rl_step[d]};
        diff = a - lo;
        code = 0;
        if (diff > 0) code = (2 * diff + st) / (2 * st);
        if (code > $signed({56'd0, lev})) code = {56'd0, lev};
        r = lo + st * code;
        sd = 65'(dot_sum) + 65'(b * r);
        if (sd > $signed({SCORE_MAX[63], SCORE_MAX})) dot_sum = SCORE_MAX;
        else if (sd < $signed({SCORE_MIN[63], SCORE_MIN})) dot_sum = SCORE_MIN;
        else dot_sum = sd[63:0];
        su = {1'b0, vnorm_sum} + {1'b0, a * a};
        vnorm_sum = su[64] ? '1 : su[63:0];
        su = {1'b0, rnorm_sum} + {1'b0, r * r};
        rnorm_sum = su[64] ? '1 : su[63:0];
        if (it.last_element) begin
          rank_insert(biased_score(dot_sum, norm_ratio_q16(vnorm_sum, rnorm_sum)),
                      it.vector_id);
          dot_sum = 0;
          vnorm_sum = 0;
          rnorm_sum = 0;
        end
      end
      REQ_EMIT: begin
        for (int i = 0; i < BEST_N; i++) begin
          o.rank = i[3:0];
          o.entry_valid = i < top_cnt;
          o.best_vector_id = o.entry_valid ? top_id[i] : '0;
          o.score = o.entry_valid ? top_score[i] : '0;
          o.last_of_run = i == BEST_N - 1;
          ranked_q.push_back(o);
        end
        top_cnt = 0;
      end
      default: ;
    endcase
  endtask

  // expected rows only where obvious; others go through the predictor
  typedef struct {
    sqd_in_t item;
    logic typed;
    sqd_out_t first;
  } stim_row_t;
  stim_row_t rows[$];

  task automatic send_item(sqd_in_t it);
    in_data = it;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_item(it);
    @(negedge clk);
    in_valid = 1'b0;
    if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 13)) @(negedge clk);
  endtask

  task automatic wait_idle();
    while (ranked_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_levels(logic [7:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    lev = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic sqd_in_t mk(sqd_req_t rq, int d, int a, int b, int id, bit l);
    sqd_in_t it;
    it.req_type = rq;
    it.dim_index = d[9:0];
    it.value_a = a[23:0];
    it.value_b = b[23:0];
    it.vector_id = id[19:0];
    it.last_element = l;
    return it;
  endfunction

  function automatic sqd_in_t rand_elem(int d, bit l);
    sqd_in_t it;
    int sel;
    int va;
    int vb;
    sel = $urandom_range(0, 9);
    it = mk(REQ_SCORE, d + DIM_DEPTH * $urandom_range(0, 3), $urandom, $urandom,
            $urandom, l);
    if (sel < 6) begin
      va = $urandom_range(0, 20'hFFFFF) - 32'sh80000;
      vb = $urandom_range(0, 20'hFFFFF) - 32'sh80000;
      it.value_a = va[23:0];
      it.value_b = vb[23:0];
    end
    return it;
  endfunction

  task automatic load_rulers(bit extreme);
    int st;
    for (int d = 0; d < RULER_DIMS; d++) begin
      st = extreme ? $urandom : $urandom_range(0, 20'h3FFFF) - 20'h100;
      send_item(mk(REQ_LOAD, d + DIM_DEPTH * $urandom_range(0, 3),
                   $urandom_range(0, 24'hFFFFFF) - (extreme ? 0 : 24'h7FFFFF), st, $urandom, 0));
    end
  endtask

  // output side: random stall bursts, checking on each transfer
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_idle <= 0;
    end else if (rx_calm) begin
      out_ready <= 1'b1;
    end else if (rx_idle != 0) begin
      rx_idle <= rx_idle - 1;
      if (rx_idle == 1) out_ready <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      rx_idle <= $urandom_range(1, 13);
    end else begin
      out_ready <= 1'b1;
    end
  end

  sqd_out_t want;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      if (ranked_q.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual %p", $time, out_data);
        errors++;
      end else begin
        want = ranked_q.pop_front();
        if (typed_pending && want.rank == 4'd0) begin
          typed_pending = 1'b0;
          if (out_data !== typed_first) begin
            $display("%0t: first rank expected %p actual %p", $time, typed_first,
                     out_data);
            errors++;
          end
        end
        if (out_data.rank !== want.rank) begin
          $display("%0t: rank expected %0d actual %0d", $time, want.rank, out_data.rank);
          errors++;
        end
        if (out_data.best_vector_id !== want.best_vector_id) begin
          $display("%0t: id expected %0h actual %0h", $time, want.best_vector_id,
                   out_data.best_vector_id);
          errors++;
        end
        if (out_data.score !== want.score) begin
          $display("%0t: score expected %0h actual %0h", $time, want.score, out_data.score);
          errors++;
        end
        if (out_data.entry_valid !== want.entry_valid) begin
          $display("%0t: entry_valid expected %0b actual %0b", $time, want.entry_valid,
                   out_data.entry_valid);
          errors++;
        end
        if (out_data.last_of_run !== want.last_of_run) begin
          $display("%0t: last_of_run expected %0b actual %0b", $time, want.last_of_run,
                   out_data.last_of_run);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("sq_decoded_ip_score_topk_top test failed");
      $finish;
    end
  end

  int vec_len;
  int vec_cnt;
  sqd_out_t blank;

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    out_ready = 1'b0;
    errors = 0;
    cycles = 0;
    calm = 1'b0;
    rx_calm = 1'b0;
    typed_pending = 1'b0;
    typed_first = '0;
    lev = LEV_RESET;
    dot_sum = 0;
    vnorm_sum = 0;
    rnorm_sum = 0;
    top_cnt = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    blank = '0;
    rows.push_back('{mk(REQ_EMIT, 0, 0, 0, 0, 0), 1'b1, blank});
    rows.push_back('{mk(REQ_LOAD, 0, 0, 0, 0, 0), 1'b0, blank});
    rows.push_back('{mk(REQ_LOAD, 1, -8388608, -8388608, 0, 0), 1'b0, blank});
    rows.push_back('{mk(REQ_LOAD, 2, 8388607, 8388607, 0, 0), 1'b0, blank});
    rows.push_back('{mk(REQ_LOAD, 1023, -65536, 4096, 0, 0), 1'b0, blank});
    rows.push_back('{mk(REQ_LOAD, 4, 0, 1, 0, 0), 1'b0, blank});
    rows.push_back('{mk(REQ_NONE, 1023, -1, -1, 1048575, 1), 1'b0, blank});
    rows.push_back('{mk(REQ_SCORE, 1, 8388607, 8388607, 0, 0), 1'b0, blank});
    rows.push_back('{mk(REQ_SCORE, 2, -8388608, -8388608, 0, 0), 1'b0, blank});
    rows.push_back('{mk(REQ_SCORE, 2047, 65536, -65536, 1048575, 1), 1'b0, blank});
    rows.push_back('{mk(REQ_SCORE, 0, 8388607, 8388607, 5, 1), 1'b0, blank});
    rows.push_back('{mk(REQ_SCORE, 4, 8388607, 8388607, 6, 1), 1'b0, blank});
    rows.push_back('{mk(REQ_SCORE, 4, 8388607, 8388607, 7, 1), 1'b0, blank});
    rows.push_back('{mk(REQ_SCORE, 4, -8388608, 8388607, 8, 1), 1'b0, blank});
    rows.push_back('{mk(REQ_SCORE, 1, 12345, 777, 9, 0), 1'b0, blank});
    rows.push_back('{mk(REQ_EMIT, 0, 0, 0, 0, 0), 1'b0, blank});
    rows.push_back('{mk(REQ_SCORE, 2, 0, 65536, 10, 1), 1'b0, blank});
    rows.push_back('{mk(REQ_EMIT, 1023, -1, -1, 1048575, 1), 1'b0, blank});
    foreach (rows[i]) begin
      if (rows[i].typed) begin
        typed_first = rows[i].first;
        typed_pending = 1'b1;
      end
      send_item(rows[i].item);
    end
    wait_idle();

    // random phases across quantizer settings; dims kept to loaded rulers
    foreach (lev_plan[k]) begin
      write_levels(lev_plan[k]);
      load_rulers(k == 1);
      if (k == 4) calm = 1'b1;
      if (k == 4) rx_calm = 1'b1;
      for (int n = 0; n < 2; n++) begin
        vec_cnt = $urandom_range(2, 5);
        for (int v = 0; v < vec_cnt; v++) begin
          vec_len = $urandom_range(1, 4);
          for (int e = 0; e < vec_len; e++) send_item(rand_elem(e, e == vec_len - 1));
        end
        if ($urandom_range(0, 4) == 0) send_item(mk(REQ_NONE, $urandom, $urandom, $urandom,
                                                    $urandom, $urandom));
        if ($urandom_range(0, 3) == 0) send_item(rand_elem(0, 0));
        send_item(mk(REQ_EMIT, $urandom, $urandom, $urandom, $urandom, $urandom));
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("sq_decoded_ip_score_topk_top test passed");
    end else begin
      $display("sq_decoded_ip_score_topk_top test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
